// ----- src/eps_pkg.sv -----
// ============================================================================
// eps_pkg
// Shared constants for the ellipse point generator: register indexes,
// mirror quadrant codes and the output coordinate width.
// ============================================================================
package eps_pkg;

    // width of the plotted coordinates
    localparam int OUT_W = 16;

    // configuration register indexes
    localparam logic [1:0] REG_CENTRE_X = 2'd0;
    localparam logic [1:0] REG_CENTRE_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS_X = 2'd2;
    localparam logic [1:0] REG_RADIUS_Y = 2'd3;

    // mirror quadrant codes, in output order
    localparam logic [1:0] QUAD_PP = 2'd0;
    localparam logic [1:0] QUAD_NP = 2'd1;
    localparam logic [1:0] QUAD_NN = 2'd2;
    localparam logic [1:0] QUAD_PN = 2'd3;

endpackage

// ----- src/eps_in_if.sv -----
// ============================================================================
// eps_in_if
// Sweep position channel: valid/ready handshake with one coordinate.
// ============================================================================
interface eps_in_if #(
    parameter int COORD_WIDTH = 14
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] sweep_pos;

    modport source (output valid, output sweep_pos, input ready);
    modport sink   (input valid, input sweep_pos, output ready);
endinterface

// ----- src/eps_out_if.sv -----
// ============================================================================
// eps_out_if
// Point channel: valid/ready handshake with one plotted mirror point.
// ============================================================================
interface eps_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [1:0]         quadrant;
    logic               last_point;

    modport source (output valid, output point_x, output point_y, output quadrant,
                    output last_point, input ready);
    modport sink   (input valid, input point_x, input point_y, input quadrant,
                    input last_point, output ready);
endinterface

// ----- src/ellipse_point_generator_unit.sv -----
// ============================================================================
// ellipse_point_generator_unit
// Four mirror points of an ellipse for each sweep position.
// ============================================================================
// Usage: write centre and radii on the configuration port while idle, then
// stream sweep positions on i_sweep. Each item yields four items on o_point
// in the order (+,+), (-,+), (-,-), (+,-); the fourth has last_point set.
// The derived offset is floor(r_o * sqrt(r_s^2 - u^2) / r_s), taken as a
// square root of the wide product followed by a division by r_s.
// Pipeline: an accepted item passes five front stages, 2*COORD_WIDTH
// square root stages, COORD_WIDTH divider stages and the output register
// before its first point shows.
// The output register hands out four points per item and takes a new item
// only while free or as the fourth point is taken; the pipeline itself takes
// an item every cycle while the output register lets it advance.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults: centre 0, radii 16.
// A stall on o_point freezes the whole pipeline; i_sweep.ready drops while
// the output register holds a point, unless that point is the fourth and is taken.
// ============================================================================
module ellipse_point_generator_unit #(
    parameter int COORD_WIDTH = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_wdata,
    eps_in_if.sink                 i_sweep,
    eps_out_if.source              o_point
);
    import eps_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int EW = (W > OUT_W) ? W : OUT_W;

    logic [W-1:0] r_cx, r_cy, r_rx, r_ry;

    logic           w_en;
    logic           w_fv, w_fsx;
    logic [4*W-1:0] w_ft;
    logic [W-1:0]   w_fu, w_frs, w_fro;
    logic           w_sv, w_ssx;
    logic [2*W-1:0] w_sroot;
    logic [W-1:0]   w_su, w_srs, w_sro;
    logic           w_dv, w_dsx;
    logic [W-1:0]   w_dq, w_du, w_drs, w_dro, w_off;

    logic         r_ov;
    logic [1:0]   r_k;
    logic [W-1:0] r_dx, r_dy;

    logic          w_negx, w_negy;
    logic [EW-1:0] w_px, w_py;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_rx <= W'(16);
            r_ry <= W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CENTRE_X: r_cx <= i_cfg_wdata;
                REG_CENTRE_Y: r_cy <= i_cfg_wdata;
                REG_RADIUS_X: r_rx <= i_cfg_wdata;
                REG_RADIUS_Y: r_ry <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advances when the output register is free or finishing
    assign w_en          = !r_ov || (o_point.ready && (r_k == QUAD_PN));
    assign i_sweep.ready = w_en;

    eps_front #(.COORD_WIDTH(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_sweep.valid),
        .i_u     (i_sweep.sweep_pos),
        .i_rx    (r_rx),
        .i_ry    (r_ry),
        .o_valid (w_fv),
        .o_t     (w_ft),
        .o_u     (w_fu),
        .o_rs    (w_frs),
        .o_ro    (w_fro),
        .o_sx    (w_fsx)
    );

    eps_sqrt #(.COORD_WIDTH(W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_t     (w_ft),
        .i_u     (w_fu),
        .i_rs    (w_frs),
        .i_ro    (w_fro),
        .i_sx    (w_fsx),
        .o_valid (w_sv),
        .o_root  (w_sroot),
        .o_u     (w_su),
        .o_rs    (w_srs),
        .o_ro    (w_sro),
        .o_sx    (w_ssx)
    );

    eps_div #(.COORD_WIDTH(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv),
        .i_num   (w_sroot),
        .i_u     (w_su),
        .i_rs    (w_srs),
        .i_ro    (w_sro),
        .i_sx    (w_ssx),
        .o_valid (w_dv),
        .o_quot  (w_dq),
        .o_u     (w_du),
        .o_rs    (w_drs),
        .o_ro    (w_dro),
        .o_sx    (w_dsx)
    );

    // zero sweep radius lands on the vertex
    assign w_off = (w_drs == '0) ? w_dro : w_dq;

    // output register, four points per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_k  <= QUAD_PP;
        end else if (w_en) begin
            r_ov <= w_dv;
            r_k  <= QUAD_PP;
        end else if (r_ov && o_point.ready) begin
            r_k <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_dv) begin
            r_dx <= w_dsx ? w_du : w_off;
            r_dy <= w_dsx ? w_off : w_du;
        end
    end

    // mirror point
    assign w_negx = (r_k == QUAD_NP) || (r_k == QUAD_NN);
    assign w_negy = (r_k == QUAD_NN) || (r_k == QUAD_PN);
    assign w_px   = w_negx ? (EW'(r_cx) - EW'(r_dx)) : (EW'(r_cx) + EW'(r_dx));
    assign w_py   = w_negy ? (EW'(r_cy) - EW'(r_dy)) : (EW'(r_cy) + EW'(r_dy));

    assign o_point.valid      = r_ov;
    assign o_point.point_x    = w_px[OUT_W-1:0];
    assign o_point.point_y    = w_py[OUT_W-1:0];
    assign o_point.quadrant   = r_k;
    assign o_point.last_point = (r_k == QUAD_PN);

`ifndef ASSERT_OFF
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_point.ready |=> r_ov && $stable(r_k) && $stable(r_dx))
        else $error("output point changed while stalled");

    a_quad_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && o_point.ready && (r_k != QUAD_PN) |=> r_ov && (r_k == 2'($past(r_k) + 2'd1)))
        else $error("quadrant sequence broken");

    a_new_item_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && w_dv |=> r_ov && (r_k == QUAD_PP))
        else $error("new item did not start at first quadrant");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv && (w_drs != '0) |-> w_dq <= w_dro)
        else $error("derived offset exceeds radius");
`endif

endmodule

// ----- src/eps_front.sv -----
// ============================================================================
// eps_front
// Front stages: axis select and saturation, squares, radicand and the
// split wide product r_o^2 * (r_s^2 - u^2).
// ============================================================================
module eps_front #(
    parameter int COORD_WIDTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [COORD_WIDTH-1:0]   i_u,
    input  logic [COORD_WIDTH-1:0]   i_rx,
    input  logic [COORD_WIDTH-1:0]   i_ry,
    output logic                     o_valid,
    output logic [4*COORD_WIDTH-1:0] o_t,
    output logic [COORD_WIDTH-1:0]   o_u,
    output logic [COORD_WIDTH-1:0]   o_rs,
    output logic [COORD_WIDTH-1:0]   o_ro,
    output logic                     o_sx
);
    localparam int W = COORD_WIDTH;

    logic         n_sx;
    logic [W-1:0] n_rs, n_ro, n_u;

    logic         r_va, r_vb, r_vc, r_vd, r_ve;
    logic [W-1:0] r_ua, r_ub, r_uc, r_ud, r_ue;
    logic [W-1:0] r_rsa, r_rsb, r_rsc, r_rsd, r_rse;
    logic [W-1:0] r_roa, r_rob, r_roc, r_rod, r_roe;
    logic         r_sxa, r_sxb, r_sxc, r_sxd, r_sxe;
    logic [2*W-1:0] r_su, r_rs2, r_ro2b, r_d, r_ro2c;
    logic [2*W-1:0] r_pp00, r_pp01, r_pp10, r_pp11;
    logic [4*W-1:0] r_t;

    // sweep axis select and saturation
    always_comb begin
        n_sx = (i_rx < i_ry);
        n_rs = n_sx ? i_rx : i_ry;
        n_ro = n_sx ? i_ry : i_rx;
        n_u  = (i_u > n_rs) ? n_rs : i_u;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage a: selected operands
            r_ua  <= n_u;
            r_rsa <= n_rs;
            r_roa <= n_ro;
            r_sxa <= n_sx;
            // stage b: squares
            r_su   <= r_ua * r_ua;
            r_rs2  <= r_rsa * r_rsa;
            r_ro2b <= r_roa * r_roa;
            r_ub <= r_ua; r_rsb <= r_rsa; r_rob <= r_roa; r_sxb <= r_sxa;
            // stage c: radicand
            r_d    <= r_rs2 - r_su;
            r_ro2c <= r_ro2b;
            r_uc <= r_ub; r_rsc <= r_rsb; r_roc <= r_rob; r_sxc <= r_sxb;
            // stage d: partial products of the wide product
            r_pp00 <= r_ro2c[W-1:0]   * r_d[W-1:0];
            r_pp01 <= r_ro2c[W-1:0]   * r_d[2*W-1:W];
            r_pp10 <= r_ro2c[2*W-1:W] * r_d[W-1:0];
            r_pp11 <= r_ro2c[2*W-1:W] * r_d[2*W-1:W];
            r_ud <= r_uc; r_rsd <= r_rsc; r_rod <= r_roc; r_sxd <= r_sxc;
            // stage e: partial product sum
            r_t <= ({r_pp11, {(2*W){1'b0}}})
                 + ((4*W)'(r_pp01) << W)
                 + ((4*W)'(r_pp10) << W)
                 + (4*W)'(r_pp00);
            r_ue <= r_ud; r_rse <= r_rsd; r_roe <= r_rod; r_sxe <= r_sxd;
        end
    end

    assign o_valid = r_ve;
    assign o_t     = r_t;
    assign o_u     = r_ue;
    assign o_rs    = r_rse;
    assign o_ro    = r_roe;
    assign o_sx    = r_sxe;

endmodule

// ----- src/eps_sqrt.sv -----
// ============================================================================
// eps_sqrt
// Pipelined integer square root, one root bit per stage.
// ============================================================================
module eps_sqrt #(
    parameter int COORD_WIDTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [4*COORD_WIDTH-1:0] i_t,
    input  logic [COORD_WIDTH-1:0]   i_u,
    input  logic [COORD_WIDTH-1:0]   i_rs,
    input  logic [COORD_WIDTH-1:0]   i_ro,
    input  logic                     i_sx,
    output logic                     o_valid,
    output logic [2*COORD_WIDTH-1:0] o_root,
    output logic [COORD_WIDTH-1:0]   o_u,
    output logic [COORD_WIDTH-1:0]   o_rs,
    output logic [COORD_WIDTH-1:0]   o_ro,
    output logic                     o_sx
);
    localparam int W  = COORD_WIDTH;
    localparam int N  = 2 * W;
    localparam int RW = 4 * W;

    logic          r_v    [N];
    logic [RW-1:0] r_rem  [N];
    logic [N-1:0]  r_root [N];
    logic [W-1:0]  r_u    [N];
    logic [W-1:0]  r_rs   [N];
    logic [W-1:0]  r_ro   [N];
    logic          r_sx   [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam int I = N - 1 - g;

        logic          w_v;
        logic [RW-1:0] w_rem, w_trial;
        logic [N-1:0]  w_root;
        logic [W-1:0]  w_u, w_rs, w_ro;
        logic          w_sx;

        // stage input
        if (g == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = i_t;
            assign w_root = '0;
            assign w_u    = i_u;
            assign w_rs   = i_rs;
            assign w_ro   = i_ro;
            assign w_sx   = i_sx;
        end else begin : g_next
            assign w_v    = r_v[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
            assign w_u    = r_u[g-1];
            assign w_rs   = r_rs[g-1];
            assign w_ro   = r_ro[g-1];
            assign w_sx   = r_sx[g-1];
        end

        // (root + 2^I)^2 - root^2
        assign w_trial = (RW'(w_root) << (I + 1)) | (RW'(1) << (2 * I));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        // one root bit decided
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem >= w_trial) begin
                    r_rem[g]  <= w_rem - w_trial;
                    r_root[g] <= w_root | (N'(1) << I);
                end else begin
                    r_rem[g]  <= w_rem;
                    r_root[g] <= w_root;
                end
                r_u[g]  <= w_u;
                r_rs[g] <= w_rs;
                r_ro[g] <= w_ro;
                r_sx[g] <= w_sx;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_u     = r_u[N-1];
    assign o_rs    = r_rs[N-1];
    assign o_ro    = r_ro[N-1];
    assign o_sx    = r_sx[N-1];

endmodule

// ----- src/eps_div.sv -----
// ============================================================================
// eps_div
// Pipelined restoring divider, root / sweep radius, one quotient bit per
// stage.
// ============================================================================
module eps_div #(
    parameter int COORD_WIDTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [2*COORD_WIDTH-1:0] i_num,
    input  logic [COORD_WIDTH-1:0]   i_u,
    input  logic [COORD_WIDTH-1:0]   i_rs,
    input  logic [COORD_WIDTH-1:0]   i_ro,
    input  logic                     i_sx,
    output logic                     o_valid,
    output logic [COORD_WIDTH-1:0]   o_quot,
    output logic [COORD_WIDTH-1:0]   o_u,
    output logic [COORD_WIDTH-1:0]   o_rs,
    output logic [COORD_WIDTH-1:0]   o_ro,
    output logic                     o_sx
);
    localparam int W = COORD_WIDTH;

    logic         r_v   [W];
    logic [W-1:0] r_rem [W];
    logic [W-1:0] r_low [W];
    logic [W-1:0] r_q   [W];
    logic [W-1:0] r_u   [W];
    logic [W-1:0] r_rs  [W];
    logic [W-1:0] r_ro  [W];
    logic         r_sx  [W];

    for (genvar g = 0; g < W; g++) begin : g_stage
        localparam int J = W - 1 - g;

        logic         w_v, w_sx, w_ge;
        logic [W-1:0] w_rem, w_low, w_q, w_u, w_rs, w_ro;
        logic [W:0]   w_sh;

        // stage input; the quotient fits W bits, so the upper half starts
        // as the remainder
        if (g == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = i_num[2*W-1:W];
            assign w_low = i_num[W-1:0];
            assign w_q   = '0;
            assign w_u   = i_u;
            assign w_rs  = i_rs;
            assign w_ro  = i_ro;
            assign w_sx  = i_sx;
        end else begin : g_next
            assign w_v   = r_v[g-1];
            assign w_rem = r_rem[g-1];
            assign w_low = r_low[g-1];
            assign w_q   = r_q[g-1];
            assign w_u   = r_u[g-1];
            assign w_rs  = r_rs[g-1];
            assign w_ro  = r_ro[g-1];
            assign w_sx  = r_sx[g-1];
        end

        assign w_sh = {w_rem, w_low[J]};
        assign w_ge = (w_sh >= {1'b0, w_rs});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        // one quotient bit decided
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_ge) begin
                    r_rem[g] <= W'(w_sh - {1'b0, w_rs});
                    r_q[g]   <= w_q | (W'(1) << J);
                end else begin
                    r_rem[g] <= w_sh[W-1:0];
                    r_q[g]   <= w_q;
                end
                r_low[g] <= w_low;
                r_u[g]   <= w_u;
                r_rs[g]  <= w_rs;
                r_ro[g]  <= w_ro;
                r_sx[g]  <= w_sx;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quot  = r_q[W-1];
    assign o_u     = r_u[W-1];
    assign o_rs    = r_rs[W-1];
    assign o_ro    = r_ro[W-1];
    assign o_sx    = r_sx[W-1];

endmodule

// ----- bench/ellipse_point_generator_unit_test.sv -----
// ============================================================================
// ellipse_point_generator_unit_test
// Streams sweep positions into the ellipse point generator under several
// centre and radius settings. Each item is predicted as four mirror points,
// and every output item is checked field by field against the oldest pending
// point. Both sides stall in random bursts, and one long output hold-off lets
// the pipeline fill up.
// ============================================================================
module ellipse_point_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import eps_pkg::*;

    localparam int CW = 14;
    localparam logic [CW-1:0] CMAX = '1;
    localparam int DRAIN_CYCLES = 3 * CW + 20;
    localparam int STALL_LIMIT = 1500;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic [1:0]              quadrant;
        logic                    last_point;
    } t_point;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [CW-1:0] i_cfg_wdata;

    eps_in_if #(.COORD_WIDTH(CW)) sweep_if ();
    eps_out_if point_if ();

    ellipse_point_generator_unit #(.COORD_WIDTH(CW)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sweep     (sweep_if.sink),
        .o_point     (point_if.source)
    );

    // shadow of the ellipse settings
    logic [CW-1:0] centre_x_q, centre_y_q, radius_x_q, radius_y_q;

    t_point pending_points[$];
    int     error_count = 0;
    bit     send_gaps_en = 1'b1;
    bit     recv_stalls_en = 1'b1;
    bit     long_hold_req = 1'b0;
    int     quiet_cycles = 0;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // largest v <= r_o with (v*r_s)^2 <= r_o^2 * (r_s^2 - u^2)
    function automatic logic [CW-1:0] derived_offset(logic [CW-1:0] u, logic [CW-1:0] r_s,
                                                     logic [CW-1:0] r_o);
        longint unsigned span, bound, prod;
        logic [CW-1:0]   v, cand;
        span  = longint'(r_s) * longint'(r_s) - longint'(u) * longint'(u);
        bound = longint'(r_o) * longint'(r_o) * span;
        v = '0;
        for (int b = CW - 1; b >= 0; b--) begin
            cand = v | (CW'(1) << b);
            if (cand <= r_o) begin
                prod = longint'(cand) * longint'(r_s);
                if (prod * prod <= bound) v = cand;
            end
        end
        return v;
    endfunction

    // four mirror points for one sweep position
    task automatic predict_points(logic [CW-1:0] u);
        logic [CW-1:0]    su, dx, dy;
        logic [OUT_W-1:0] xp, xn, yp, yn;
        t_point           pt;
        su = u;
        if (radius_x_q < radius_y_q) begin
            if (su > radius_x_q) su = radius_x_q;
            dx = su;
            dy = derived_offset(su, radius_x_q, radius_y_q);
        end else begin
            if (su > radius_y_q) su = radius_y_q;
            dy = su;
            dx = derived_offset(su, radius_y_q, radius_x_q);
        end
        xp = OUT_W'(centre_x_q) + OUT_W'(dx);
        xn = OUT_W'(centre_x_q) - OUT_W'(dx);
        yp = OUT_W'(centre_y_q) + OUT_W'(dy);
        yn = OUT_W'(centre_y_q) - OUT_W'(dy);
        pt = '{xp, yp, QUAD_PP, 1'b0};
        pending_points.push_back(pt);
        pt = '{xn, yp, QUAD_NP, 1'b0};
        pending_points.push_back(pt);
        pt = '{xn, yn, QUAD_NN, 1'b0};
        pending_points.push_back(pt);
        pt = '{xp, yn, QUAD_PN, 1'b1};
        pending_points.push_back(pt);
    endtask

    // send one sweep position; called at a rising edge, returns at the accepting edge
    task automatic send_sweep(logic [CW-1:0] u);
        if (send_gaps_en && $urandom_range(0, 3) == 0) begin
            sweep_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        sweep_if.valid     <= 1'b1;
        sweep_if.sweep_pos <= u;
        do @(negedge i_clk); while (!sweep_if.ready);
        @(posedge i_clk);
        predict_points(u);
    endtask

    task automatic end_burst();
        sweep_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // let every pending point drain and the pipeline empty
    task automatic wait_drained();
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all four registers on consecutive edges while idle
    task automatic set_ellipse(logic [CW-1:0] cx, logic [CW-1:0] cy,
                               logic [CW-1:0] rx, logic [CW-1:0] ry);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_CENTRE_X;
        i_cfg_wdata <= cx;
        @(posedge i_clk);
        i_cfg_index <= REG_CENTRE_Y;
        i_cfg_wdata <= cy;
        @(posedge i_clk);
        i_cfg_index <= REG_RADIUS_X;
        i_cfg_wdata <= rx;
        @(posedge i_clk);
        i_cfg_index <= REG_RADIUS_Y;
        i_cfg_wdata <= ry;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        centre_x_q = cx;
        centre_y_q = cy;
        radius_x_q = rx;
        radius_y_q = ry;
        @(posedge i_clk);
    endtask

    // sweep values around the edges of the sweep radius
    task automatic send_edge_sweeps(logic [CW-1:0] r);
        send_sweep('0);
        send_sweep(r >> 1);
        send_sweep(r);
        if (r != CMAX) send_sweep(r + 1'b1);
        send_sweep(CMAX);
        end_burst();
    endtask

    task automatic test_reset_defaults();
        centre_x_q = '0;
        centre_y_q = '0;
        radius_x_q = CW'(16);
        radius_y_q = CW'(16);
        send_edge_sweeps(CW'(16));
    endtask

    task automatic test_sweep_along_x();
        set_ellipse(CW'(4000), CW'(5000), CW'(300), CW'(1200));
        send_edge_sweeps(CW'(300));
    endtask

    task automatic test_sweep_along_y();
        set_ellipse(CW'(7000), CW'(3000), CW'(2500), CW'(700));
        send_edge_sweeps(CW'(700));
    endtask

    task automatic test_extremes();
        // largest ellipse at the origin: offsets wrap below zero
        set_ellipse('0, '0, CMAX, CMAX);
        send_sweep('0);
        send_sweep(CW'(14'h2AAA));
        send_sweep(CW'(14'h1555));
        send_sweep(CMAX);
        end_burst();
        // far corner with tiny radii
        set_ellipse(CMAX, CMAX, CW'(1), CW'(1));
        send_sweep('0);
        send_sweep(CMAX);
        end_burst();
        // very flat ellipses both ways
        set_ellipse(CMAX, '0, CW'(1), CMAX);
        send_sweep('0);
        send_sweep(CW'(1));
        end_burst();
        set_ellipse('0, CMAX, CMAX, CW'(1));
        send_sweep('0);
        send_sweep(CMAX);
        end_burst();
    endtask

    task automatic test_long_stall();
        set_ellipse(CW'(8000), CW'(8000), CW'(900), CW'(1600));
        long_hold_req = 1'b1;
        for (int n = 0; n < 24; n++) send_sweep(CW'($urandom_range(0, 900)));
        end_burst();
    endtask

    task automatic test_random_sweeps(int settings, int per_setting);
        logic [CW-1:0] rx, ry, rs;
        for (int s = 0; s < settings; s++) begin
            if ($urandom_range(0, 2) == 0) begin
                rx = CW'($urandom_range(1, 64));
                ry = CW'($urandom_range(1, 64));
            end else begin
                rx = CW'($urandom_range(1, CMAX));
                ry = CW'($urandom_range(1, CMAX));
            end
            set_ellipse(CW'($urandom_range(0, CMAX)), CW'($urandom_range(0, CMAX)), rx, ry);
            rs = (rx < ry) ? rx : ry;
            for (int n = 0; n < per_setting; n++) begin
                if ($urandom_range(0, 4) == 0) send_sweep(CW'($urandom_range(0, CMAX)));
                else send_sweep(CW'($urandom_range(0, rs)));
            end
            end_burst();
        end
    endtask

    task automatic test_no_idling();
        send_gaps_en   = 1'b0;
        recv_stalls_en = 1'b0;
        set_ellipse(CW'(9000), CW'(2000), CW'(1800), CW'(1800));
        for (int n = 0; n < 20; n++) send_sweep(CW'($urandom_range(0, 1900)));
        end_burst();
    endtask

    // output ready: random bursts of stalls, plus one long hold-off on request
    initial begin
        point_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                point_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                point_if.ready <= 1'b1;
            end else if (recv_stalls_en && $urandom_range(0, 5) == 0) begin
                point_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                point_if.ready <= 1'b1;
            end else begin
                point_if.ready <= 1'b1;
            end
        end
    end

    // point checker; handshake signals are stable at the falling edge
    always @(negedge i_clk) begin
        t_point exp_pt;
        if (i_rst_n && point_if.valid && point_if.ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected point item x=%0d y=%0d", point_if.point_x, point_if.point_y);
                error_count++;
            end else begin
                exp_pt = pending_points.pop_front();
                if (point_if.point_x !== exp_pt.point_x) begin
                    $error("point_x expected %0d actual %0d", exp_pt.point_x, point_if.point_x);
                    error_count++;
                end
                if (point_if.point_y !== exp_pt.point_y) begin
                    $error("point_y expected %0d actual %0d", exp_pt.point_y, point_if.point_y);
                    error_count++;
                end
                if (point_if.quadrant !== exp_pt.quadrant) begin
                    $error("quadrant expected %0d actual %0d", exp_pt.quadrant,
                           point_if.quadrant);
                    error_count++;
                end
                if (point_if.last_point !== exp_pt.last_point) begin
                    $error("last_point expected %0d actual %0d", exp_pt.last_point,
                           point_if.last_point);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(negedge i_clk) begin
        if ((sweep_if.valid && sweep_if.ready) || (point_if.valid && point_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL ellipse_point_generator_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // main sequence
    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= REG_CENTRE_X;
        i_cfg_wdata        <= '0;
        sweep_if.valid     <= 1'b0;
        sweep_if.sweep_pos <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_sweep_along_x();
        test_sweep_along_y();
        test_extremes();
        test_long_stall();
        test_random_sweeps(6, 10);
        test_no_idling();

        wait_drained();
        if (error_count == 0) begin
            $display("PASS ellipse_point_generator_unit");
        end else begin
            $display("FAIL ellipse_point_generator_unit");
        end
        $finish;
    end

endmodule

// ----- ellipse_point_generator_unit.f -----
src/eps_pkg.sv
src/eps_in_if.sv
src/eps_out_if.sv
src/eps_front.sv
src/eps_sqrt.sv
src/eps_div.sv
src/ellipse_point_generator_unit.sv
bench/ellipse_point_generator_unit_test.sv
